// ===== hdl/ehp_pkg.sv =====
package ehp_pkg;

  localparam int MAX_VLAN_TAGS   = 8;
  localparam int MAX_EXT_HEADERS = 16;
  localparam int HDR_BYTES       = 40;
  localparam int VLAN_IW = (MAX_VLAN_TAGS > 1) ? $clog2(MAX_VLAN_TAGS) : 1;
  localparam int EXT_CW  = $clog2(MAX_EXT_HEADERS + 1);

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86dd;
  localparam logic [15:0] ETH_VLAN = 16'h8100;
  localparam logic [15:0] ETH_QINQ = 16'h88a8;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
  localparam logic [7:0] EXT_HOPOPT   = 8'd0;
  localparam logic [7:0] EXT_ROUTING  = 8'd43;
  localparam logic [7:0] EXT_FRAG     = 8'd44;
  localparam logic [7:0] EXT_DSTOPT   = 8'd60;
  localparam logic [7:0] EXT_MOBILITY = 8'd135;
  localparam logic [7:0] EXT_HIP      = 8'd139;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_MALF  = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  localparam logic [2:0] L4_NONE   = 3'd0;
  localparam logic [2:0] L4_TCP    = 3'd1;
  localparam logic [2:0] L4_UDP    = 3'd2;
  localparam logic [2:0] L4_ICMP   = 3'd3;
  localparam logic [2:0] L4_ICMPV6 = 3'd4;
  localparam logic [2:0] L4_OTHER  = 3'd5;

  localparam logic [4:0] K_STATUS  = 5'd0;
  localparam logic [4:0] K_DMAC    = 5'd1;
  localparam logic [4:0] K_SMAC    = 5'd2;
  localparam logic [4:0] K_ETYPE   = 5'd3;
  localparam logic [4:0] K_VLAN    = 5'd4;
  localparam logic [4:0] K_IPINFO  = 5'd5;
  localparam logic [4:0] K_ADDR0   = 5'd6;
  localparam logic [4:0] K_ADDR3   = 5'd9;
  localparam logic [4:0] K_FRAG    = 5'd10;
  localparam logic [4:0] K_L4      = 5'd11;
  localparam logic [4:0] K_TCPSEQ  = 5'd12;
  localparam logic [4:0] K_TCPHDR  = 5'd13;
  localparam logic [4:0] K_UDPLEN  = 5'd14;
  localparam logic [4:0] K_ICMP    = 5'd15;
  localparam logic [4:0] K_PAYLOAD = 5'd16;

  typedef enum logic [11:0] {
    PH_ETH     = 12'b000000000001,
    PH_VLAN    = 12'b000000000010,
    PH_IP4     = 12'b000000000100,
    PH_IP4OPT  = 12'b000000001000,
    PH_IP6     = 12'b000000010000,
    PH_EXT     = 12'b000000100000,
    PH_EXTSKIP = 12'b000001000000,
    PH_FRAG    = 12'b000010000000,
    PH_TCP     = 12'b000100000000,
    PH_UDP     = 12'b001000000000,
    PH_ICMP    = 12'b010000000000,
    PH_DONE    = 12'b100000000000
  } phase_t;

  // Parser state carried from byte to byte within one frame.
  typedef struct packed {
    phase_t             phase;
    logic [5:0]         poff;
    logic [16:0]        pos;
    logic [16:0]        hs;
    logic [47:0]        mac0;
    logic [47:0]        mac1;
    logic               eth;
    logic [15:0]        etype;
    logic               typ;
    logic [3:0]         vcnt;
    logic [3:0][63:0]   addr;
    logic [39:0]        ip;
    logic [17:0]        frag;
    logic [2:0]         l4;
    logic [15:0]        sport;
    logic [15:0]        dport;
    logic [63:0]        tf1;
    logic [31:0]        tf2;
    logic [17:0]        poffo;
    logic [17:0]        plen;
    logic [EXT_CW-1:0]  extc;
    logic [7:0]         nh;
    logic [17:0]        req;
    logic               endk;
    logic [17:0]        skip;
    logic [16:0]        ips;
    logic [5:0]         iphl;
    logic [15:0]        iptot;
    logic [1:0]         ff;
    logic               done;
  } fstate_t;

  localparam fstate_t FS_RESET = '{phase: PH_ETH, default: '0};

  // Everything the result side needs to emit the words of one frame.
  typedef struct packed {
    logic [1:0]                     status;
    logic                           eth;
    logic                           typ;
    logic [3:0]                     vcnt;
    logic                           ipok;
    logic [2:0]                     l4;
    logic [47:0]                    mac0;
    logic [47:0]                    mac1;
    logic [15:0]                    etype;
    logic [MAX_VLAN_TAGS-1:0][11:0] vlan;
    logic [39:0]                    ip;
    logic [3:0][63:0]               addr;
    logic [17:0]                    frag;
    logic [15:0]                    sport;
    logic [15:0]                    dport;
    logic [63:0]                    tf1;
    logic [31:0]                    tf2;
    logic [17:0]                    poffo;
    logic [17:0]                    plen;
  } rec_t;

endpackage

// ===== hdl/ehp_front.sv =====
module ehp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [55:0]   in_tdata,
  input  logic          in_tuser,
  input  logic          in_tlast,
  input  logic          q_full,
  output logic          push,
  output ehp_pkg::rec_t push_rec
);
  import ehp_pkg::*;

  fstate_t              s_r;
  fstate_t              s_nxt;
  logic [7:0]           hdr_r [HDR_BYTES];
  logic [11:0]          vlan_r [MAX_VLAN_TAGS];
  logic                 fire;
  logic                 take;
  logic                 collect;
  logic                 vlan_we;
  logic [11:0]          vlan_wd;
  logic [VLAN_IW-1:0]   vlan_wa;
  logic [7:0]           data_byte;
  logic [15:0]          cap_len;
  logic [31:0]          orig_len;

  assign data_byte = in_tdata[7:0];
  assign cap_len   = in_tdata[23:8];
  assign orig_len  = in_tdata[55:24];
  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;
  assign take      = fire && in_tuser && !s_r.pos[16];
  assign collect   = !(s_r.phase == PH_DONE || s_r.phase == PH_IP4OPT
                       || s_r.phase == PH_EXTSKIP);
  assign push      = fire && in_tlast;

  function automatic logic [5:0] need(input phase_t ph);
    logic [5:0] n;
    unique case (ph)
      PH_ETH:  n = 6'd14;
      PH_VLAN: n = 6'd4;
      PH_IP4:  n = 6'd20;
      PH_IP6:  n = 6'd40;
      PH_EXT:  n = 6'd2;
      PH_FRAG: n = 6'd8;
      PH_TCP:  n = 6'd20;
      PH_UDP:  n = 6'd8;
      PH_ICMP: n = 6'd4;
      default: n = 6'd1;
    endcase
    return n;
  endfunction

  always_comb begin
    fstate_t     s;
    logic [7:0]  he [HDR_BYTES];
    logic        hd;
    logic        go_type;
    logic        go_ip4;
    logic        go_ext;
    logic        go_enter;
    logic        go_other;
    logic        coded;
    logic        malf;
    logic        ipok;
    logic [1:0]  st;
    logic [16:0] p;
    logic [17:0] av;
    logic [17:0] hs_av;
    logic [17:0] o_off;
    logic [17:0] o_len;
    logic [7:0]  proto;
    logic [7:0]  nhv;
    logic [5:0]  hl;
    logic [16:0] v17;
    logic [15:0] v16;

    s        = s_r;
    hd       = 1'b0;
    go_type  = 1'b0;
    go_ip4   = 1'b0;
    go_ext   = 1'b0;
    go_enter = 1'b0;
    go_other = 1'b0;
    coded    = 1'b0;
    av       = '0;
    hs_av    = s_r.req - {1'b0, s_r.hs};
    o_off    = '0;
    o_len    = '0;
    proto    = '0;
    nhv      = '0;
    hl       = '0;
    v17      = '0;
    v16      = '0;
    vlan_we  = 1'b0;
    vlan_wd  = '0;
    vlan_wa  = s_r.vcnt[VLAN_IW-1:0];
    p        = s_r.pos + 17'd1;
    for (int i = 0; i < HDR_BYTES; i++) begin
      he[i] = (s_r.poff == 6'(i)) ? data_byte : hdr_r[i];
    end

    if (take) begin
      s.pos = p;
      unique case (s_r.phase)
        PH_DONE: ;
        PH_IP4OPT:  go_ip4 = ({1'b0, p} >= s_r.skip);
        PH_EXTSKIP: go_ext = ({1'b0, p} >= s_r.skip);
        default: begin
          s.poff = s_r.poff + 6'd1;
          hd     = (s.poff >= need(s_r.phase));
        end
      endcase
    end

    if (hd) begin
      unique case (s_r.phase)
        PH_ETH: begin
          s.mac0  = {he[0], he[1], he[2], he[3], he[4], he[5]};
          s.mac1  = {he[6], he[7], he[8], he[9], he[10], he[11]};
          s.eth   = 1'b1;
          s.etype = {he[12], he[13]};
          go_type = 1'b1;
        end
        PH_VLAN: begin
          vlan_we = (s_r.vcnt < 4'(MAX_VLAN_TAGS));
          vlan_wd = {he[0][3:0], he[1]};
          s.vcnt  = s_r.vcnt + 4'd1;
          s.etype = {he[2], he[3]};
          go_type = 1'b1;
        end
        PH_IP4: begin
          hl = {he[0][3:0], 2'b00};
          if (he[0][7:4] != 4'd4 || hl < 6'd20) begin
            s.ff = ST_MALF; s.done = 1'b1; s.phase = PH_DONE;
          end else begin
            v16          = {he[6], he[7]};
            s.ips        = s_r.hs;
            s.iphl       = hl;
            s.iptot      = {he[2], he[3]};
            s.ip         = {he[9], he[2], he[3], he[8], 8'd4};
            s.frag[15:0] = {v16[12:0], 3'b000};
            s.frag[16]   = v16[13];
            s.frag[17]   = (v16[12:0] != 13'd0) || v16[13];
            s.addr[0]    = {32'd0, he[12], he[13], he[14], he[15]};
            s.addr[1]    = '0;
            s.addr[2]    = {32'd0, he[16], he[17], he[18], he[19]};
            s.addr[3]    = '0;
            s.skip       = {1'b0, s_r.hs} + 18'(hl);
            if ({1'b0, p} >= s.skip) go_ip4 = 1'b1;
            else s.phase = PH_IP4OPT;
          end
        end
        PH_IP6: begin
          if (he[0][7:4] != 4'd6) begin
            s.ff = ST_MALF; s.done = 1'b1; s.phase = PH_DONE;
          end else begin
            v17  = {1'b0, he[4], he[5]} + 17'd40;
            s.req  = {1'b0, s_r.hs} + {1'b0, v17};
            s.endk = 1'b1;
            s.ip   = {8'd0, (v17[16] ? 16'hffff : v17[15:0]), he[7], 8'd6};
            s.addr[0] = {he[8], he[9], he[10], he[11], he[12], he[13], he[14], he[15]};
            s.addr[1] = {he[16], he[17], he[18], he[19], he[20], he[21], he[22], he[23]};
            s.addr[2] = {he[24], he[25], he[26], he[27], he[28], he[29], he[30], he[31]};
            s.addr[3] = {he[32], he[33], he[34], he[35], he[36], he[37], he[38], he[39]};
            s.nh   = he[6];
            s.extc = '0;
            go_ext = 1'b1;
          end
        end
        PH_FRAG: begin
          v16    = {he[2], he[3]};
          s.frag = {1'b1, v16[0], v16[15:3], 3'b000};
          s.nh   = he[0];
          go_ext = 1'b1;
        end
        PH_EXT: begin
          s.nh    = he[0];
          s.skip  = {1'b0, s_r.hs} + {6'd0, ({1'b0, he[1]} + 9'd1), 3'b000};
          s.phase = PH_EXTSKIP;
        end
        PH_TCP: begin
          hl = {he[12][7:4], 2'b00};
          if (hl < 6'd20 || 18'(hl) > hs_av) begin
            s.ff = ST_MALF; s.done = 1'b1; s.phase = PH_DONE;
          end else begin
            s.l4    = L4_TCP;
            s.sport = {he[0], he[1]};
            s.dport = {he[2], he[3]};
            s.tf1   = {he[4], he[5], he[6], he[7], he[8], he[9], he[10], he[11]};
            s.tf2   = {he[14], he[15], he[13], 2'b00, hl};
            s.poffo = {1'b0, s_r.hs} + 18'(hl);
            s.plen  = hs_av - 18'(hl);
            s.ff = ST_VALID; s.done = 1'b1; s.phase = PH_DONE;
          end
        end
        PH_UDP: begin
          v16 = {he[4], he[5]};
          if (v16 < 16'd8) begin
            s.ff = ST_MALF; s.done = 1'b1; s.phase = PH_DONE;
          end else if ({2'b00, v16} > hs_av) begin
            s.ff = ST_TRUNC; s.done = 1'b1; s.phase = PH_DONE;
          end else begin
            s.l4    = L4_UDP;
            s.sport = {he[0], he[1]};
            s.dport = {he[2], he[3]};
            s.tf1   = {48'd0, v16};
            s.poffo = {1'b0, s_r.hs} + 18'd8;
            s.plen  = {2'b00, v16 - 16'd8};
            s.ff = ST_VALID; s.done = 1'b1; s.phase = PH_DONE;
          end
        end
        PH_ICMP: begin
          s.l4    = (s_r.ip[39:32] == PROTO_ICMP) ? L4_ICMP : L4_ICMPV6;
          s.tf1   = {48'd0, he[1], he[0]};
          s.poffo = {1'b0, s_r.hs} + 18'd4;
          s.plen  = hs_av - 18'd4;
          s.ff = ST_VALID; s.done = 1'b1; s.phase = PH_DONE;
        end
        default: ;
      endcase
    end

    // Another tag is followed only while tag slots remain.
    if (go_type) begin
      if ((s.etype == ETH_VLAN || s.etype == ETH_QINQ)
          && s.vcnt < 4'(MAX_VLAN_TAGS)) begin
        s.phase = PH_VLAN; s.poff = '0; s.hs = p;
      end else begin
        s.typ = 1'b1;
        if (s.etype == ETH_IPV4) begin
          s.phase = PH_IP4; s.poff = '0; s.hs = p;
        end else if (s.etype == ETH_IPV6) begin
          s.phase = PH_IP6; s.poff = '0; s.hs = p;
        end else begin
          s.ff = ST_UNSUP; s.done = 1'b1; s.phase = PH_DONE;
        end
      end
    end

    if (go_ip4) begin
      if (s.iptot < {10'd0, s.iphl}) begin
        s.ff = ST_MALF; s.done = 1'b1; s.phase = PH_DONE;
      end else begin
        s.req  = {1'b0, s.ips} + {2'b00, s.iptot};
        s.endk = 1'b1;
        if (s.frag[15:0] != 16'd0) begin
          go_other = 1'b1;
          o_off    = {1'b0, s.ips} + 18'(s.iphl);
          o_len    = {2'b00, s.iptot - {10'd0, s.iphl}};
        end else begin
          go_enter = 1'b1;
          proto    = s.ip[39:32];
        end
      end
    end

    if (go_ext) begin
      nhv   = s.nh;
      coded = (nhv == EXT_HOPOPT || nhv == EXT_ROUTING || nhv == EXT_DSTOPT
               || nhv == EXT_MOBILITY || nhv == EXT_HIP);
      if (s.extc < EXT_CW'(MAX_EXT_HEADERS) && (coded || nhv == EXT_FRAG)) begin
        s.extc  = s.extc + 1'b1;
        s.phase = (nhv == EXT_FRAG) ? PH_FRAG : PH_EXT;
        s.poff  = '0;
        s.hs    = p;
      end else begin
        s.ip[39:32] = nhv;
        if ({1'b0, p} > s.req) begin
          s.ff = ST_MALF; s.done = 1'b1; s.phase = PH_DONE;
        end else if (s.frag[15:0] != 16'd0) begin
          go_other = 1'b1;
          o_off    = {1'b0, p};
          o_len    = s.req - {1'b0, p};
        end else begin
          go_enter = 1'b1;
          proto    = nhv;
        end
      end
    end

    if (go_enter) begin
      av          = s.req - {1'b0, p};
      s.ip[39:32] = proto;
      if (proto == PROTO_TCP) begin
        if (av < 18'd20) begin
          s.ff = ST_TRUNC; s.done = 1'b1; s.phase = PH_DONE;
        end else begin
          s.phase = PH_TCP; s.poff = '0; s.hs = p;
        end
      end else if (proto == PROTO_UDP) begin
        if (av < 18'd8) begin
          s.ff = ST_TRUNC; s.done = 1'b1; s.phase = PH_DONE;
        end else begin
          s.phase = PH_UDP; s.poff = '0; s.hs = p;
        end
      end else if (proto == PROTO_ICMP || proto == PROTO_ICMPV6) begin
        if (av < 18'd4) begin
          s.ff = ST_TRUNC; s.done = 1'b1; s.phase = PH_DONE;
        end else begin
          s.phase = PH_ICMP; s.poff = '0; s.hs = p;
        end
      end else begin
        go_other = 1'b1;
        o_off    = {1'b0, p};
        o_len    = av;
      end
    end

    if (go_other) begin
      s.l4    = L4_OTHER;
      s.poffo = o_off;
      s.plen  = o_len;
      s.ff = ST_VALID; s.done = 1'b1; s.phase = PH_DONE;
    end

    s_nxt = s;

    malf = ({1'b0, s.pos} != {2'b00, cap_len}) || (orig_len < {16'd0, cap_len});
    ipok = s.endk && ({1'b0, s.pos} >= s.req);
    if (s.endk && !ipok) st = ST_TRUNC;
    else if (s.done) st = s.ff;
    else st = ST_TRUNC;

    push_rec.status = malf ? ST_MALF : st;
    push_rec.eth    = !malf && s.eth;
    push_rec.typ    = !malf && s.typ;
    push_rec.vcnt   = malf ? 4'd0 : s.vcnt;
    push_rec.ipok   = !malf && ipok;
    push_rec.l4     = (!malf && st == ST_VALID) ? s.l4 : L4_NONE;
    push_rec.mac0   = s.mac0;
    push_rec.mac1   = s.mac1;
    push_rec.etype  = s.etype;
    for (int i = 0; i < MAX_VLAN_TAGS; i++) begin
      push_rec.vlan[i] = (vlan_we && vlan_wa == VLAN_IW'(i)) ? vlan_wd : vlan_r[i];
    end
    push_rec.ip     = s.ip;
    push_rec.addr   = s.addr;
    push_rec.frag   = s.frag;
    push_rec.sport  = s.sport;
    push_rec.dport  = s.dport;
    push_rec.tf1    = s.tf1;
    push_rec.tf2    = s.tf2;
    push_rec.poffo  = s.poffo;
    push_rec.plen   = s.plen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= FS_RESET;
    end else if (fire) begin
      s_r <= in_tlast ? FS_RESET : s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && collect && s_r.poff < 6'(HDR_BYTES)) begin
      hdr_r[s_r.poff] <= data_byte;
    end
    if (vlan_we) begin
      vlan_r[vlan_wa] <= vlan_wd;
    end
  end

endmodule

// ===== hdl/ehp_queue.sv =====
module ehp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ehp_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output ehp_pkg::rec_t head_rec
);
  import ehp_pkg::*;

  // Two slots; slot 0 is always the head, so a pop shifts slot 1 forward.
  logic v0_r, v1_r, v0_nxt, v1_nxt;
  rec_t s0_r, s1_r, s0_nxt, s1_nxt;

  assign full       = v1_r;
  assign head_valid = v0_r;
  assign head_rec   = s0_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (pop && v0_r) begin
      v0_nxt = v1_r;
      s0_nxt = s1_r;
      v1_nxt = 1'b0;
    end
    if (push) begin
      if (!v0_nxt) begin
        v0_nxt = 1'b1;
        s0_nxt = push_rec;
      end else begin
        v1_nxt = 1'b1;
        s1_nxt = push_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

endmodule

// ===== hdl/ehp_back.sv =====
module ehp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  ehp_pkg::rec_t head_rec,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,
  output logic [4:0]    out_tuser,
  output logic          out_tlast
);
  import ehp_pkg::*;

  logic [4:0]         kind_r;
  logic [VLAN_IW-1:0] vidx_r;
  logic               ov_r;
  logic [63:0]        data_r;
  logic [4:0]         user_r;
  logic               last_r;
  logic               load;
  logic               stay;
  logic               found;
  logic               last;
  logic [4:0]         nk;
  logic [63:0]        word;

  function automatic logic appl(input logic [4:0] c, input rec_t r);
    logic a;
    unique case (c) inside
      K_DMAC, K_SMAC:        a = r.eth;
      K_ETYPE:               a = r.typ;
      K_VLAN:                a = (r.vcnt != 4'd0);
      [K_IPINFO:K_FRAG]:     a = r.ipok;
      K_L4, K_PAYLOAD:       a = (r.l4 != L4_NONE);
      K_TCPSEQ, K_TCPHDR:    a = (r.l4 == L4_TCP);
      K_UDPLEN:              a = (r.l4 == L4_UDP);
      K_ICMP:                a = (r.l4 == L4_ICMP || r.l4 == L4_ICMPV6);
      default:               a = 1'b0;
    endcase
    return a;
  endfunction

  always_comb begin
    stay  = (kind_r == K_VLAN) && ((4'(vidx_r) + 4'd1) < head_rec.vcnt);
    found = 1'b0;
    nk    = K_STATUS;
    for (int c = 1; c <= 16; c++) begin
      if (!found && 5'(c) > kind_r && appl(5'(c), head_rec)) begin
        found = 1'b1;
        nk    = 5'(c);
      end
    end
    last = !stay && !found;

    case (kind_r)
      K_STATUS: word = {62'd0, head_rec.status};
      K_DMAC:   word = {16'd0, head_rec.mac0};
      K_SMAC:   word = {16'd0, head_rec.mac1};
      K_ETYPE:  word = {48'd0, head_rec.etype};
      K_VLAN:   word = {44'd0, 4'(vidx_r), 4'd0, head_rec.vlan[vidx_r]};
      K_IPINFO: word = {24'd0, head_rec.ip};
      K_FRAG:   word = {46'd0, head_rec.frag};
      K_L4:     word = {16'd0, head_rec.dport, head_rec.sport, 13'd0, head_rec.l4};
      K_TCPHDR: word = {32'd0, head_rec.tf2};
      K_TCPSEQ, K_UDPLEN, K_ICMP: word = head_rec.tf1;
      K_PAYLOAD: word = {14'd0, head_rec.plen, 14'd0, head_rec.poffo};
      default: begin
        if (kind_r >= K_ADDR0 && kind_r <= K_ADDR3) word = head_rec.addr[2'(kind_r - K_ADDR0)];
        else word = '0;
      end
    endcase
  end

  assign load       = head_valid && (!ov_r || out_tready);
  assign pop        = load && last;
  assign out_tvalid = ov_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      kind_r <= K_STATUS;
      vidx_r <= '0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
        if (last) begin
          kind_r <= K_STATUS;
          vidx_r <= '0;
        end else if (stay) begin
          vidx_r <= vidx_r + 1'b1;
        end else begin
          kind_r <= nk;
          vidx_r <= '0;
        end
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= word;
      user_r <= kind_r;
      last_r <= last;
    end
  end

endmodule

// ===== hdl/ethernet_ip_header_parser.sv =====
// Takes one frame byte per cycle; the input stalls only while two finished frames
// still wait for their result words to drain.
// A frame's result words wait in the frame queue and leave one word per cycle while
// out_tready is high (up to 22 words), limited by the single output register.
// Reset is synchronous and active low; it empties the parser and the frame queue.
module ethernet_ip_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // data_byte[7:0], cap_len[23:8], wire_len[55:24]
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // result_value[63:0]
  output logic [4:0]  out_tuser,  // result_kind[4:0]
  output logic        out_tlast
);
  import ehp_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic head_valid;
  rec_t push_rec;
  rec_t head_rec;

  ehp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  ehp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  ehp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/ethernet_ip_header_parser_tb.sv =====
`timescale 1ns / 1ps

module ethernet_ip_header_parser_tb;
  import ehp_pkg::*;

  typedef struct {
    bit [7:0]  d;
    bit        pres;
    bit        last;
    bit [15:0] cap;
    bit [31:0] orig;
    bit        hold;
  } byte_req_t;

  typedef struct {
    bit [4:0]  kind;
    bit [63:0] val;
    bit        last;
  } word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // data_byte[7:0], cap_len[23:8], wire_len[55:24]
  logic        in_tuser;   // byte_present
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // result_value[63:0]
  logic [4:0]  out_tuser;  // result_kind[4:0]
  logic        out_tlast;

  ethernet_ip_header_parser u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  byte_req_t pending_bytes[$];
  word_t     expected_words[$];
  bit [7:0]  fb[$];
  int        errors = 0;
  int        frames_taken = 0;
  bit        stall_done = 0;

  // Parser shadow state, cleared at reset and after every frame.
  bit [7:0]    hdr_buf[40];
  bit [31:0]   pos, poff, hstart, etype, vcnt, ext_cnt, nxt, req_end, skip_end;
  bit [31:0]   ip_st, ip_hl, ip_tot, fragf;
  bit [31:0]   vid[MAX_VLAN_TAGS];
  bit [63:0]   mac[2];
  bit [63:0]   addr[4];
  bit [63:0]   ipf;
  bit [63:0]   tf[4];
  bit          eth_ok, type_ok, endk, done;
  bit [2:0]    l4k;
  bit [1:0]    fail;
  phase_t      ph;

  function automatic bit [31:0] hb(bit [31:0] i);
    return i < 40 ? {24'd0, hdr_buf[i]} : 32'd0;
  endfunction

  function automatic bit [31:0] be16(bit [31:0] i);
    return (hb(i) << 8) | hb(i + 1);
  endfunction

  function automatic bit [31:0] be32(bit [31:0] i);
    return (be16(i) << 16) | be16(i + 2);
  endfunction

  function automatic bit [63:0] be_n(bit [31:0] i, int n);
    bit [63:0] v;
    v = 0;
    for (int k = 0; k < n; k++) v = (v << 8) | 64'(hb(i + 32'(k)));
    return v;
  endfunction

  function automatic void close_parse(bit [1:0] st);
    fail = st;
    done = 1;
    ph = PH_DONE;
  endfunction

  function automatic void open_phase(phase_t p);
    ph = p;
    poff = 0;
    hstart = pos;
  endfunction

  function automatic void set_proto(bit [31:0] p);
    ipf[39:32] = p[7:0];
  endfunction

  function automatic void opaque_payload(bit [31:0] off, bit [31:0] len);
    l4k = L4_OTHER;
    tf[0] = 64'(L4_OTHER);
    tf[3] = {len, off};
    close_parse(ST_VALID);
  endfunction

  function automatic void enter_l4(bit [31:0] proto);
    bit [31:0] avail;
    avail = req_end - pos;
    set_proto(proto);
    if (proto == PROTO_TCP) begin
      if (avail < 20) close_parse(ST_TRUNC); else open_phase(PH_TCP);
    end else if (proto == PROTO_UDP) begin
      if (avail < 8) close_parse(ST_TRUNC); else open_phase(PH_UDP);
    end else if (proto == PROTO_ICMP || proto == PROTO_ICMPV6) begin
      if (avail < 4) close_parse(ST_TRUNC); else open_phase(PH_ICMP);
    end else begin
      opaque_payload(pos, avail);
    end
  endfunction

  function automatic void after_type();
    if ((etype == ETH_VLAN || etype == ETH_QINQ) && vcnt < MAX_VLAN_TAGS) begin
      open_phase(PH_VLAN);
      return;
    end
    type_ok = 1;
    if (etype == ETH_IPV4) open_phase(PH_IP4);
    else if (etype == ETH_IPV6) open_phase(PH_IP6);
    else close_parse(ST_UNSUP);
  endfunction

  function automatic void ip4_after_opts();
    if (ip_tot < ip_hl) begin
      close_parse(ST_MALF);
      return;
    end
    req_end = ip_st + ip_tot;
    endk = 1;
    if (fragf[15:0] != 0) opaque_payload(ip_st + ip_hl, ip_tot - ip_hl);
    else enter_l4({24'd0, ipf[39:32]});
  endfunction

  function automatic void walk_ext();
    bit coded;
    coded = nxt == EXT_HOPOPT || nxt == EXT_ROUTING || nxt == EXT_DSTOPT ||
            nxt == EXT_MOBILITY || nxt == EXT_HIP;
    if (ext_cnt < MAX_EXT_HEADERS && (coded || nxt == EXT_FRAG)) begin
      ext_cnt++;
      open_phase(nxt == EXT_FRAG ? PH_FRAG : PH_EXT);
      return;
    end
    set_proto(nxt);
    if (pos > req_end) begin
      close_parse(ST_MALF);
      return;
    end
    if (fragf[15:0] != 0) opaque_payload(pos, req_end - pos);
    else enter_l4(nxt);
  endfunction

  function automatic void header_complete(phase_t p);
    bit [31:0] avail, v, hl;
    avail = req_end - hstart;
    case (p)
      PH_ETH: begin
        mac[0] = be_n(0, 6);
        mac[1] = be_n(6, 6);
        eth_ok = 1;
        etype = be16(12);
        after_type();
      end
      PH_VLAN: begin
        if (vcnt < MAX_VLAN_TAGS) vid[vcnt] = be16(0) & 32'h0fff;
        vcnt++;
        etype = be16(2);
        after_type();
      end
      PH_IP4: begin
        hl = (hb(0) & 32'hf) * 4;
        if ((hb(0) >> 4) != 4 || hl < 20) begin
          close_parse(ST_MALF);
        end else begin
          ip_st = hstart;
          ip_hl = hl;
          ip_tot = be16(2);
          ipf = 64'd4 | (64'(hb(8)) << 8) | (64'(ip_tot) << 16) | (64'(hb(9)) << 32);
          v = be16(6);
          fragf = (v & 32'h1fff) * 8;
          if (v & 32'h2000) fragf |= 32'h10000;
          if (fragf != 0) fragf |= 32'h20000;
          addr[0] = 64'(be32(12));
          addr[1] = 64'd0;
          addr[2] = 64'(be32(16));
          addr[3] = 64'd0;
          skip_end = ip_st + hl;
          if (pos >= skip_end) ip4_after_opts();
          else ph = PH_IP4OPT;
        end
      end
      PH_IP6: begin
        if ((hb(0) >> 4) != 6) begin
          close_parse(ST_MALF);
        end else begin
          v = be16(4) + 40;
          req_end = hstart + v;
          endk = 1;
          ipf = 64'd6 | (64'(hb(7)) << 8) | (64'(v > 65535 ? 32'd65535 : v) << 16);
          for (int k = 0; k < 4; k++) addr[k] = be_n(32'(8 + 8 * k), 8);
          nxt = hb(6);
          ext_cnt = 0;
          walk_ext();
        end
      end
      PH_FRAG: begin
        v = be16(2);
        fragf = ((v >> 3) & 32'h1fff) * 8 | ((v & 1) << 16) | 32'h20000;
        nxt = hb(0);
        walk_ext();
      end
      PH_EXT: begin
        nxt = hb(0);
        skip_end = hstart + (hb(1) + 1) * 8;
        ph = PH_EXTSKIP;
      end
      PH_TCP: begin
        hl = (hb(12) >> 4) * 4;
        if (hl < 20 || hl > avail) begin
          close_parse(ST_MALF);
        end else begin
          l4k = L4_TCP;
          tf[0] = 64'(L4_TCP) | (64'(be16(0)) << 16) | (64'(be16(2)) << 32);
          tf[1] = {be32(4), be32(8)};
          tf[2] = 64'(hl | (hb(13) << 8) | (be16(14) << 16));
          tf[3] = {avail - hl, hstart + hl};
          close_parse(ST_VALID);
        end
      end
      PH_UDP: begin
        v = be16(4);
        if (v < 8) close_parse(ST_MALF);
        else if (v > avail) close_parse(ST_TRUNC);
        else begin
          l4k = L4_UDP;
          tf[0] = 64'(L4_UDP) | (64'(be16(0)) << 16) | (64'(be16(2)) << 32);
          tf[1] = 64'(v);
          tf[3] = {v - 32'd8, hstart + 32'd8};
          close_parse(ST_VALID);
        end
      end
      PH_ICMP: begin
        l4k = (ipf[39:32] == PROTO_ICMP) ? L4_ICMP : L4_ICMPV6;
        tf[0] = 64'(l4k);
        tf[1] = 64'(hb(0) | (hb(1) << 8));
        tf[3] = {avail - 32'd4, hstart + 32'd4};
        close_parse(ST_VALID);
      end
      default: ;
    endcase
  endfunction

  function automatic bit [31:0] header_size(phase_t p);
    case (p)
      PH_ETH:  return 14;
      PH_VLAN: return 4;
      PH_IP4:  return 20;
      PH_IP6:  return 40;
      PH_EXT:  return 2;
      PH_FRAG: return 8;
      PH_TCP:  return 20;
      PH_UDP:  return 8;
      PH_ICMP: return 4;
      default: return 1;
    endcase
  endfunction

  function automatic void take_byte(bit [7:0] b);
    phase_t p;
    p = ph;
    pos++;
    if (p == PH_DONE) return;
    if (p == PH_IP4OPT) begin
      if (pos >= skip_end) ip4_after_opts();
      return;
    end
    if (p == PH_EXTSKIP) begin
      if (pos >= skip_end) walk_ext();
      return;
    end
    if (poff < 40) hdr_buf[poff] = b;
    poff++;
    if (poff >= header_size(p)) header_complete(p);
  endfunction

  function automatic void clear_parser();
    pos = 0; poff = 0; hstart = 0; etype = 0; vcnt = 0; ext_cnt = 0; nxt = 0;
    req_end = 0; skip_end = 0; ip_st = 0; ip_hl = 0; ip_tot = 0; fragf = 0;
    eth_ok = 0; type_ok = 0; endk = 0; done = 0; l4k = L4_NONE; fail = ST_VALID;
    ipf = 0;
    for (int k = 0; k < 40; k++) hdr_buf[k] = 0;
    for (int k = 0; k < MAX_VLAN_TAGS; k++) vid[k] = 0;
    for (int k = 0; k < 2; k++) mac[k] = 0;
    for (int k = 0; k < 4; k++) begin
      addr[k] = 0;
      tf[k] = 0;
    end
    open_phase(PH_ETH);
  endfunction

  function automatic void add_word(ref word_t q[$], input bit [4:0] k, input bit [63:0] v);
    word_t w;
    w.kind = k;
    w.val = v;
    w.last = 0;
    q.insert(q.size(), w);
  endfunction

  // Advances the shadow parser by one request and queues the words of a closed frame.
  function automatic void parse_request(byte_req_t r);
    word_t     q[$];
    bit        ipok;
    bit [1:0]  st;
    if (r.pres && pos < 65536) take_byte(r.d);
    if (!r.last) return;
    if (pos != 32'(r.cap) || r.orig < 32'(r.cap)) begin
      add_word(q, K_STATUS, 64'(ST_MALF));
    end else begin
      ipok = endk && pos >= req_end;
      if (endk && !ipok) st = ST_TRUNC;
      else if (done) st = fail;
      else st = ST_TRUNC;
      add_word(q, K_STATUS, 64'(st));
      if (eth_ok) begin
        add_word(q, K_DMAC, mac[0]);
        add_word(q, K_SMAC, mac[1]);
      end
      if (type_ok) add_word(q, K_ETYPE, 64'(etype));
      for (int k = 0; k < vcnt && k < MAX_VLAN_TAGS; k++)
        add_word(q, K_VLAN, 64'(vid[k]) | (64'(k) << 16));
      if (ipok) begin
        add_word(q, K_IPINFO, ipf);
        for (int k = 0; k < 4; k++) add_word(q, 5'(K_ADDR0 + k), addr[k]);
        add_word(q, K_FRAG, 64'(fragf));
        if (st == ST_VALID && l4k != L4_NONE) begin
          add_word(q, K_L4, tf[0]);
          if (l4k == L4_TCP) begin
            add_word(q, K_TCPSEQ, tf[1]);
            add_word(q, K_TCPHDR, tf[2]);
          end else if (l4k == L4_UDP) begin
            add_word(q, K_UDPLEN, tf[1]);
          end else if (l4k == L4_ICMP || l4k == L4_ICMPV6) begin
            add_word(q, K_ICMP, tf[1]);
          end
          add_word(q, K_PAYLOAD, tf[3]);
        end
      end
    end
    q[q.size() - 1].last = 1;
    foreach (q[k]) expected_words.insert(expected_words.size(), q[k]);
    clear_parser();
  endfunction

  // ---------------- frame construction ----------------

  function automatic void add_byte(ref bit [7:0] q[$], input bit [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void put16(bit [15:0] v);
    add_byte(fb, v[15:8]);
    add_byte(fb, v[7:0]);
  endfunction

  function automatic void put_rand(int n);
    for (int k = 0; k < n; k++) add_byte(fb, 8'($urandom));
  endfunction

  // l3: 0 ipv4, 1 ipv6, 2 other ethertype; l4: 0 tcp, 1 udp, 2 icmp, 3 other.
  function automatic void build_frame(int l3, int l4, int ntags, int nexts, bit errs);
    bit [7:0] lb[$];
    bit [7:0] ext_types[$];
    bit [7:0] eb[$];
    bit [7:0] proto, nh;
    int       doff, pl, hl, ihl;
    bit [15:0] tot;
    bit [7:0] codes[6] = '{EXT_HOPOPT, EXT_ROUTING, EXT_DSTOPT, EXT_MOBILITY, EXT_HIP,
                           EXT_FRAG};
    fb.delete();
    put_rand(12);
    for (int k = 0; k < ntags; k++) begin
      put16($urandom_range(0, 1) ? ETH_VLAN : ETH_QINQ);
      put_rand(2);
    end
    if (l3 == 0) put16(ETH_IPV4);
    else if (l3 == 1) put16(ETH_IPV6);
    else put16(16'($urandom));
    if (l3 == 2) begin
      put_rand($urandom_range(0, 30));
      return;
    end
    pl = $urandom_range(0, 12);
    // transport header and payload
    if (l4 == 0) begin
      proto = PROTO_TCP;
      doff = (errs && $urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(5, 6);
      for (int k = 0; k < 12; k++) add_byte(lb, 8'($urandom));
      add_byte(lb, {4'(doff), 4'($urandom)});
      for (int k = 0; k < 7; k++) add_byte(lb, 8'($urandom));
      for (int k = 5; k < doff; k++) begin
        for (int j = 0; j < 4; j++) add_byte(lb, 8'($urandom));
      end
    end else if (l4 == 1) begin
      proto = PROTO_UDP;
      tot = (errs && $urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(8 + pl);
      for (int k = 0; k < 4; k++) add_byte(lb, 8'($urandom));
      add_byte(lb, tot[15:8]);
      add_byte(lb, tot[7:0]);
      add_byte(lb, 8'($urandom));
      add_byte(lb, 8'($urandom));
    end else if (l4 == 2) begin
      proto = (l3 == 0) ? PROTO_ICMP : PROTO_ICMPV6;
      for (int k = 0; k < 4; k++) add_byte(lb, 8'($urandom));
    end else begin
      proto = 8'($urandom);
    end
    for (int k = 0; k < pl; k++) add_byte(lb, 8'($urandom));
    if (l3 == 0) begin
      ihl = (errs && $urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(5, 7);
      hl = ihl < 5 ? 20 : ihl * 4;
      tot = (errs && $urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(hl + lb.size());
      add_byte(fb, {(errs && $urandom_range(0, 19) == 0) ? 4'($urandom) : 4'd4, 4'(ihl)});
      add_byte(fb, 8'($urandom));
      put16(tot);
      put_rand(2);
      put16($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom) & 16'h4000);
      add_byte(fb, 8'($urandom));
      add_byte(fb, proto);
      put_rand(10 + hl - 20);
    end else begin
      for (int k = 0; k < nexts; k++) add_byte(ext_types, codes[$urandom_range(0, 5)]);
      for (int k = 0; k < nexts; k++) begin
        nh = (k + 1 < nexts) ? ext_types[k + 1] : proto;
        add_byte(eb, nh);
        if (ext_types[k] == EXT_FRAG) begin
          add_byte(eb, 8'($urandom));
          tot = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
          add_byte(eb, tot[15:8]);
          add_byte(eb, tot[7:0]);
          for (int j = 0; j < 4; j++) add_byte(eb, 8'($urandom));
        end else begin
          hl = $urandom_range(0, 1);
          add_byte(eb, 8'(hl));
          for (int j = 0; j < (hl + 1) * 8 - 2; j++) add_byte(eb, 8'($urandom));
        end
      end
      tot = (errs && $urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(eb.size() + lb.size());
      add_byte(fb, {(errs && $urandom_range(0, 19) == 0) ? 4'($urandom) : 4'd6,
                    4'($urandom)});
      put_rand(3);
      put16(tot);
      add_byte(fb, nexts > 0 ? ext_types[0] : proto);
      put_rand(33);
      foreach (eb[k]) add_byte(fb, eb[k]);
    end
    foreach (lb[k]) add_byte(fb, lb[k]);
  endfunction

  // Turns the frame under construction into requests, with optional length errors.
  function automatic void queue_frame(bit errs, bit hold);
    byte_req_t r;
    bit [15:0] cap;
    bit [31:0] orig;
    int        sel;
    sel = errs ? $urandom_range(0, 19) : 19;
    if (sel == 0 && fb.size() > 0) begin
      int keep;
      keep = $urandom_range(0, fb.size() - 1);
      while (fb.size() > keep) void'(fb.pop_back());
    end else if (sel == 1) begin
      put_rand($urandom_range(1, 6));
    end
    cap = 16'(fb.size());
    if (sel == 2) cap = 16'($urandom);
    orig = $urandom;
    if (orig < 32'(cap)) orig = 32'(cap) + $urandom_range(0, 100);
    if (sel == 3 && cap > 0) orig = $urandom_range(0, cap - 1);
    r.hold = hold;
    for (int k = 0; k <= fb.size(); k++) begin
      if (k < fb.size() && $urandom_range(0, 24) == 0) begin
        r.d = 8'($urandom); r.pres = 0; r.last = 0; r.cap = 16'($urandom); r.orig = $urandom;
        pending_bytes.insert(pending_bytes.size(), r);
        r.hold = 0;
      end
      if (k == fb.size() && fb.size() > 0) break;
      r.pres = fb.size() > 0;
      r.d = fb.size() > 0 ? fb[k] : 8'($urandom);
      r.last = (k + 1 >= fb.size());
      r.cap = (r.last || $urandom_range(0, 1)) ? cap : 16'($urandom);
      r.orig = (r.last || $urandom_range(0, 1)) ? orig : $urandom;
      pending_bytes.insert(pending_bytes.size(), r);
      r.hold = 0;
    end
  endfunction

  function automatic void random_frame(bit hold);
    int l3, l4, nt, ne;
    l3 = $urandom_range(0, 19) < 9 ? 0 : ($urandom_range(0, 10) < 8 ? 1 : 2);
    l4 = $urandom_range(0, 3);
    nt = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 9);
    ne = $urandom_range(0, 19) == 0 ? 17 : $urandom_range(0, 3);
    build_frame(l3, l4, nt, ne, 1);
    queue_frame(1, hold);
  endfunction

  // ---------------- clock, driver, monitor ----------------

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  int        send_gap;
  bit        send_burst;
  byte_req_t cur_req;

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
      in_tuser <= 0;
      in_tlast <= 0;
      send_gap <= 0;
      send_burst <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_request(cur_req);
        if (cur_req.last) frames_taken++;
        if ($urandom_range(0, 49) == 0) send_burst <= !send_burst;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 0;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].hold && expected_words.size() > 0)) begin
          cur_req = pending_bytes.pop_front();
          in_tdata <= {cur_req.orig, cur_req.cap, cur_req.d};
          in_tuser <= cur_req.pres;
          in_tlast <= cur_req.last;
          in_tvalid <= 1;
          send_gap <= pick_gap(send_burst);
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  int recv_hold;

  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      out_tready <= 0;
      recv_hold <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word kind=%0d value=%h last=%0b",
                   $time, out_tuser, out_tdata, out_tlast);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (w.kind !== out_tuser || w.val !== out_tdata || w.last !== out_tlast) begin
            $display("%0t: expected kind=%0d value=%h last=%0b, got kind=%0d value=%h last=%0b",
                     $time, w.kind, w.val, w.last, out_tuser, out_tdata, out_tlast);
            errors++;
          end
        end
      end
      // One long hold-off while the sender keeps offering, to back up the frame queue.
      if (!stall_done && frames_taken == 2 && in_tvalid) begin
        stall_done <= 1;
        recv_hold <= 400;
        out_tready <= 0;
      end else if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_tready <= 0;
      end else if (pick_gap(send_burst) > 0) begin
        recv_hold <= pick_gap(0);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    #3000000;
    $display("ethernet_ip_header_parser_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n = 0;
    clear_parser();
    // Directed frames: empty frame, transports over both IP versions, a VLAN stack
    // past the tag limit, extension headers, random length errors and an unsupported ethertype.
    fb.delete();
    queue_frame(0, 0);
    build_frame(0, 0, 0, 0, 0); queue_frame(0, 0);
    build_frame(0, 1, 1, 0, 0); queue_frame(0, 0);
    build_frame(1, 2, 0, 2, 0); queue_frame(0, 1);
    build_frame(2, 3, 9, 0, 0); queue_frame(0, 0);
    build_frame(0, 1, 0, 0, 0); queue_frame(1, 0);
    random_frame(0);
    repeat (7) @(posedge clk);
    rst_n <= 1;
    while (pending_bytes.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("ethernet_ip_header_parser_tb: PASS");
    end else begin
      $display("ethernet_ip_header_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
